// ----- design/bfba_pkg.sv -----
package bfba_pkg;

   localparam int LANES     = 8;
   localparam int LANE_BITS = 3;

   localparam logic [1:0] STATUS_PLACED   = 2'd0;
   localparam logic [1:0] STATUS_OVERSIZE = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic oversized;
      logic no_bins;
      logic last_row;
      logic rsp_busy;
   } sts_type;

endpackage

// ----- design/best_fit_bin_allocator.sv -----
// Channel   Ports                     Content
// -------   -----------------------   --------------------------------------------------
// req       req_tvalid/tready/tdata   one item to place: size, first-of-problem flag
// rsp       rsp_tvalid/tready/tdata   one item per request: bin, bins open, status
// csr       csr_valid/ready/data      bin capacity for newly opened bins
//
// An item is accepted in idle and steps through the start, scan, drain and commit
// states; the open bins are read eight at a time, one row of the lane memories per
// cycle, and the next item is taken once the result is written. Oversized items and
// items arriving with no bin open go from start straight to commit.
// Synchronous reset clears the bin count and sets the capacity to 65535; the
// capacity table needs no clearing. A held result does not block the next
// item's scan; only the final write-back waits for the output register.
module best_fit_bin_allocator #(
   parameter int MAX_BINS   = 256,
   parameter int SIZE_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // item_size
   input  logic        req_tuser,   // first_item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // bin_index[7:0], bins_in_use[16:8], zero pad
   output logic [2:0]  rsp_tuser,   // opened_new_bin[0], status[2:1]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // bin_capacity
);
   import bfba_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bfba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bfba_datapath #(
      .MAX_BINS   (MAX_BINS),
      .SIZE_WIDTH (SIZE_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// ----- design/bfba_ctrl.sv -----
module bfba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  bfba_pkg::sts_type sts,
   output bfba_pkg::cmd_type cmd
);
   import bfba_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (sts.oversized || sts.no_bins) begin
               state_in = ST_COMMIT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.last_row) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!sts.rsp_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/bfba_datapath.sv -----
module bfba_datapath #(
   parameter int MAX_BINS   = 256,
   parameter int SIZE_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [15:0]       req_tdata,
   input  logic              req_tuser,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,
   output logic [2:0]        rsp_tuser,
   input  bfba_pkg::cmd_type cmd,
   output bfba_pkg::sts_type sts
);
   import bfba_pkg::*;

   localparam int SW   = SIZE_WIDTH;
   localparam int ROWS = (MAX_BINS + LANES - 1) / LANES;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IW   = RW + LANE_BITS;
   localparam int CW   = $clog2(MAX_BINS + 1);
   localparam int CW1  = CW + 1;
   localparam logic [SW-1:0] CAP_RESET = SW'(32'h0000_FFFF);

   logic [SW-1:0] cap_ff;
   logic [SW-1:0] size_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [RW-1:0] row_ff;
   logic [RW-1:0] cmp_row_ff;
   logic          cmp_valid_ff;
   logic [SW-1:0] rd_data_ff [LANES];

   logic          found_ff;
   logic [SW-1:0] best_cap_ff;
   logic [IW-1:0] best_idx_ff;

   logic                 rsp_tvalid_ff;
   logic [7:0]           rsp_index_ff;
   logic [8:0]           rsp_count_ff;
   logic                 rsp_opened_ff;
   logic [1:0]           rsp_status_ff;

   logic [CW1-1:0]       rows_used;
   logic [LANES-1:0]     lane_ok;
   logic                 row_found;
   logic [SW-1:0]        row_min;
   logic [LANE_BITS-1:0] row_lane;

   logic                 wr_en;
   logic [IW-1:0]        wr_idx;
   logic [SW-1:0]        wr_data;
   logic [IW-1:0]        res_idx;
   logic                 res_opened;
   logic [1:0]           res_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_valid) begin
         cap_ff <= SW'(csr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         size_ff <= SW'(req_tdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rows_used = (CW1'(count_ff) + CW1'(LANES - 1)) >> LANE_BITS;

   assign sts.oversized = size_ff > cap_ff;
   assign sts.no_bins   = count_ff == '0;
   assign sts.last_row  = (CW1'(row_ff) + CW1'(1)) == rows_used;
   assign sts.rsp_busy  = rsp_tvalid_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmd.scan;
      end
   end

   always_ff @(posedge clock) begin
      cmp_row_ff <= row_ff;
      if (cmd.load) begin
         row_ff <= '0;
      end else if (cmd.scan) begin
         row_ff <= row_ff + RW'(1);
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [SW-1:0] rem_mem [ROWS];

      always_ff @(posedge clock) begin
         if (wr_en && wr_idx[LANE_BITS-1:0] == LANE_BITS'(l)) begin
            rem_mem[wr_idx[IW-1:LANE_BITS]] <= wr_data;
         end
         rd_data_ff[l] <= rem_mem[row_ff];
      end

      assign lane_ok[l] = cmp_valid_ff
                          && (32'({cmp_row_ff, LANE_BITS'(l)}) < 32'(count_ff))
                          && (rd_data_ff[l] >= size_ff);
   end

   // tightest fit in the row; strict compare keeps the lowest lane on a tie
   always_comb begin
      row_found = 1'b0;
      row_min   = '0;
      row_lane  = '0;
      for (int l = 0; l < LANES; l++) begin
         if (lane_ok[l] && (!row_found || rd_data_ff[l] < row_min)) begin
            row_found = 1'b1;
            row_min   = rd_data_ff[l];
            row_lane  = LANE_BITS'(l);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         found_ff <= 1'b0;
      end else if (row_found && (!found_ff || row_min < best_cap_ff)) begin
         found_ff    <= 1'b1;
         best_cap_ff <= row_min;
         best_idx_ff <= {cmp_row_ff, row_lane};
      end
   end

   always_comb begin
      count_in   = count_ff;
      wr_en      = 1'b0;
      wr_idx     = best_idx_ff;
      wr_data    = best_cap_ff - size_ff;
      res_idx    = '0;
      res_opened = 1'b0;
      res_status = STATUS_PLACED;
      if (cmd.load && req_tuser) begin
         count_in = '0;
      end
      if (sts.oversized) begin
         res_status = STATUS_OVERSIZE;
      end else if (found_ff) begin
         wr_en   = cmd.commit;
         res_idx = best_idx_ff;
      end else if (32'(count_ff) < 32'(MAX_BINS)) begin
         wr_en      = cmd.commit;
         wr_idx     = IW'(count_ff);
         wr_data    = cap_ff - size_ff;
         res_idx    = IW'(count_ff);
         res_opened = 1'b1;
         if (cmd.commit) begin
            count_in = count_ff + CW'(1);
         end
      end else begin
         res_status = STATUS_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_index_ff  <= 8'(res_idx);
         rsp_count_ff  <= 9'(count_in);
         rsp_opened_ff <= res_opened;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'd0, rsp_count_ff, rsp_index_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_opened_ff};

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import bfba_pkg::*;

   localparam int MAX_BINS    = 256;
   localparam int LATENCY     = 40;
   localparam int QUIET_LIMIT = 1000;

   typedef struct packed {
      logic [7:0] bin_index;
      logic       opened_new_bin;
      logic [8:0] bins_in_use;
      logic [1:0] status;
   } placement_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   logic [15:0]   bin_capacity;
   logic [15:0]   room_left [MAX_BINS];
   int            open_bins;
   placement_type expected_placements[$];

   int mismatches;
   int quiet_cycles;
   int req_gap_pct;
   int rsp_stall_pct;

   best_fit_bin_allocator #(
      .MAX_BINS   (MAX_BINS),
      .SIZE_WIDTH (16)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic placement_type place_item(input logic [15:0] size, input logic first);
      placement_type res;
      int            best;
      res = '0;
      res.status = STATUS_PLACED;
      best = -1;
      if (first) begin
         open_bins = 0;
      end
      if (size > bin_capacity) begin
         res.status = STATUS_OVERSIZE;
      end else begin
         // strict compare keeps the lowest index on a tie
         for (int j = 0; j < open_bins; j++) begin
            if (room_left[j] >= size && (best < 0 || room_left[j] < room_left[best])) begin
               best = j;
            end
         end
         if (best >= 0) begin
            room_left[best] = room_left[best] - size;
            res.bin_index = best[7:0];
         end else if (open_bins < MAX_BINS) begin
            room_left[open_bins] = bin_capacity - size;
            res.bin_index = open_bins[7:0];
            res.opened_new_bin = 1'b1;
            open_bins++;
         end else begin
            res.status = STATUS_FULL;
         end
      end
      res.bins_in_use = open_bins[8:0];
      return res;
   endfunction

   function automatic logic [15:0] pick_size(input int cap);
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) begin
         return '0;
      end
      if (roll < 10 && cap < 65535) begin
         return 16'($urandom_range(65535, cap + 1));
      end
      if (roll < 50) begin
         return 16'($urandom_range(cap, cap / 2));
      end
      return 16'($urandom_range(cap / 2, 0));
   endfunction

   task automatic send_item(input logic [15:0] size, input logic first);
      @(negedge clock);
      if (req_gap_pct > 0 && $urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(18, 1)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= size;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      expected_placements = {expected_placements, place_item(size, first)};
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_placements.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] value);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      bin_capacity = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_empty_and_exact_fit();
      send_item(16'h0000, 1'b1);
      send_item(16'hFFFF, 1'b0);
      send_item(16'h0000, 1'b0);
      send_item(16'hFFFF, 1'b0);
      send_item(16'h0001, 1'b0);
      send_item(16'h0000, 1'b0);
      send_item(16'h5555, 1'b0);
      send_item(16'hAAAA, 1'b0);
      send_item(16'h5555, 1'b0);
      send_item(16'hFFFF, 1'b1);
   endtask

   task automatic test_capacity_edges();
      write_capacity(16'd0);
      send_item(16'd0, 1'b1);
      send_item(16'd1, 1'b0);
      send_item(16'd0, 1'b0);
      send_item(16'd1, 1'b1);
      write_capacity(16'd1);
      send_item(16'd1, 1'b1);
      send_item(16'd1, 1'b0);
      send_item(16'd0, 1'b0);
      send_item(16'd2, 1'b0);
      // open bins keep their room across a capacity change
      write_capacity(16'd1000);
      send_item(16'd500, 1'b0);
      write_capacity(16'd100);
      send_item(16'd400, 1'b0);
      send_item(16'd100, 1'b0);
      send_item(16'd60, 1'b0);
   endtask

   task automatic test_full_table();
      write_capacity(16'hFFFF);
      for (int i = 0; i < MAX_BINS; i++) begin
         send_item(16'hFFFF, logic'(i == 0));
      end
      send_item(16'd1, 1'b0);
      send_item(16'd0, 1'b0);
      send_item(16'hFFFF, 1'b0);
      write_capacity(16'd100);
      send_item(16'd101, 1'b0);
      send_item(16'd0, 1'b1);
   endtask

   task automatic run_problems(input logic [15:0] cap, input int items, input int gap_pct,
                               input int stall_pct, input bit fill_table);
      logic [15:0] sizes[$];
      int          len;
      int          sent;
      bit          noisy;
      write_capacity(cap);
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      if (fill_table) begin
         // every item above half the capacity needs a bin of its own
         for (int k = 0; k < MAX_BINS + 4; k++) begin
            sizes = {sizes, 16'($urandom_range(cap, cap / 2 + 1))};
         end
         sizes.rsort();
         foreach (sizes[k]) begin
            send_item(sizes[k], logic'(k == 0));
         end
         sent = sizes.size();
      end
      while (sent < items) begin
         len = $urandom_range(60, 1);
         noisy = ($urandom_range(9) == 0);
         sizes.delete();
         for (int k = 0; k < len; k++) begin
            sizes = {sizes, (noisy ? 16'($urandom()) : pick_size(cap))};
         end
         if (!noisy) begin
            sizes.rsort();
         end
         foreach (sizes[k]) begin
            send_item(sizes[k], noisy ? logic'($urandom_range(1)) : logic'(k == 0));
         end
         sent += len;
      end
   endtask

   task automatic test_random_problems();
      run_problems(16'hFFFF, 180, 30, 30, 1'b0);
      run_problems(16'd1, 150, 20, 40, 1'b0);
      run_problems(16'($urandom_range(65535, 1)), 180, 0, 0, 1'b0);
      run_problems(16'd16, 180, 40, 10, 1'b0);
      run_problems(16'd300, 280, 30, 30, 1'b1);
      run_problems(16'($urandom_range(65535, 1)), 180, 25, 25, 1'b0);
      run_problems(16'hFFFF, 280, 50, 50, 1'b1);
      run_problems(16'($urandom_range(65535, 1)), 180, 0, 0, 1'b0);
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stall_pct > 0 && $urandom_range(99) < rsp_stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(18, 1) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      placement_type got;
      placement_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.bin_index      = rsp_tdata[7:0];
         got.bins_in_use    = rsp_tdata[16:8];
         got.opened_new_bin = rsp_tuser[0];
         got.status         = rsp_tuser[2:1];
         if (expected_placements.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected item: bin %0d new %0d in_use %0d status %0d",
                        got.bin_index, got.opened_new_bin, got.bins_in_use, got.status);
            end
         end else begin
            want = expected_placements.pop_front();
            if (got.bin_index !== want.bin_index || got.opened_new_bin !== want.opened_new_bin ||
                got.bins_in_use !== want.bins_in_use || got.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: bin %0d/%0d new %0d/%0d in_use %0d/%0d status %0d/%0d",
                           got.bin_index, want.bin_index, got.opened_new_bin,
                           want.opened_new_bin, got.bins_in_use, want.bins_in_use,
                           got.status, want.status);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb failed");
            $finish;
         end
      end
   end

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      bin_capacity  = 16'hFFFF;
      open_bins     = 0;
      mismatches    = 0;
      quiet_cycles  = 0;
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_empty_and_exact_fit();
      test_capacity_edges();
      test_full_table();
      test_random_problems();
      wait_idle();
      if (mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
